@@ src/kbl_pkg.sv @@
// package for the keyboard latch with key queue
// holds queue sizing, action codes and the fifo control/status structs; no dependencies
package kbl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W = 16;
    localparam int CODE_W = 8;
    localparam int IDX_W  = 8;

    localparam logic [ADDR_W-1:0] DATA_ADDR_RST   = 16'hC000;
    localparam logic [ADDR_W-1:0] STROBE_ADDR_RST = 16'hC010;
    localparam logic [CODE_W-1:0] AVAIL_BIT       = 8'h80;
    localparam logic [CODE_W-1:0] ZERO_BYTE       = 8'h00;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_PRESS   = 2'd2,
        ACT_RELEASE = 2'd3
    } kbl_action_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DATA_ADDR   = 8'd0,
        REG_STROBE_ADDR = 8'd1
    } kbl_reg_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CODE_W-1:0] wr_data;
    } kbl_fifo_ctrl_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [CODE_W-1:0] head_data;
    } kbl_fifo_stat_t;

endpackage

@@ src/kbl_key_fifo.sv @@
// key code queue: register storage, head pointer and fill count
// depends on kbl_pkg
module kbl_key_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  kbl_pkg::kbl_fifo_ctrl_t ctrl,
    output kbl_pkg::kbl_fifo_stat_t stat
);
    import kbl_pkg::*;

    logic [CODE_W-1:0] store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W:0]    wr_sum;
    logic [PTR_W-1:0]  wr_ptr;

    // tail = (head + count) mod depth, sum stays below twice the depth
    always_comb begin
        wr_sum = {{(CNT_W+1-PTR_W){1'b0}}, head_reg} + {1'b0, count_reg};
        if (wr_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            wr_sum = wr_sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        wr_ptr = wr_sum[PTR_W-1:0];
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
            if (head_reg == PTR_W'(QUEUE_DEPTH - 1)) begin
                head_next = '0;
            end else begin
                head_next = head_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            store_reg[wr_ptr] <= ctrl.wr_data;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.head_data = store_reg[head_reg];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fifo count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> !stat.full)
        else $error("push into full fifo");

    a_pop_moves_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.pop && !ctrl.push && !stat.empty) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not drop count");

endmodule

@@ src/keyboard_latch_with_key_queue_top.sv @@
// keyboard data/strobe latch with a queue of key codes and a held-key map
// depends on kbl_pkg and kbl_key_fifo
// the result beat is registered and offered in the cycle after its input beat is taken;
// throughput one beat per cycle: a new beat is taken whenever the result register is empty or being drained
// reset (aresetn low, synchronous) empties the queue, clears the held map, clears the
// strobe and restores both bus addresses; queue storage itself is not cleared
module keyboard_latch_with_key_queue_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kbl_pkg::IDX_W-1:0]   cfg_index,
    input  logic [kbl_pkg::ADDR_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [kbl_pkg::ADDR_W-1:0]  s_address,
    input  logic [kbl_pkg::CODE_W-1:0]  s_key_code,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [kbl_pkg::CODE_W-1:0]  m_read_data,
    output logic                        m_key_dropped
);
    import kbl_pkg::*;

    logic [ADDR_W-1:0] data_addr_reg, strobe_addr_reg;
    logic              strobe_clr_reg, strobe_clr_next;
    logic [255:0]      held_reg;
    logic              held_set, held_clr;
    logic              m_valid_reg;
    logic [CODE_W-1:0] rd_reg, rd_next;
    logic              drop_reg, drop_next;
    logic              accept;
    kbl_action_t       act;
    kbl_fifo_ctrl_t    fifo_ctrl;
    kbl_fifo_stat_t    fifo_stat;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign act       = kbl_action_t'(s_action);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_addr_reg   <= DATA_ADDR_RST;
            strobe_addr_reg <= STROBE_ADDR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DATA_ADDR:   data_addr_reg   <= cfg_data;
                REG_STROBE_ADDR: strobe_addr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        rd_next           = ZERO_BYTE;
        drop_next         = 1'b0;
        strobe_clr_next   = strobe_clr_reg;
        held_set          = 1'b0;
        held_clr          = 1'b0;
        fifo_ctrl.push    = 1'b0;
        fifo_ctrl.pop     = 1'b0;
        fifo_ctrl.wr_data = s_key_code;
        case (act)
            ACT_READ: begin
                // data address wins when both registers match
                if (s_address == data_addr_reg) begin
                    if (!fifo_stat.empty) begin
                        rd_next         = fifo_stat.head_data | AVAIL_BIT;
                        strobe_clr_next = 1'b0;
                    end
                end else if (s_address == strobe_addr_reg) begin
                    rd_next = strobe_clr_reg ? ZERO_BYTE : AVAIL_BIT;
                    if (!strobe_clr_reg && !fifo_stat.empty) begin
                        fifo_ctrl.pop   = accept;
                        strobe_clr_next = 1'b1;
                    end
                end
            end
            ACT_PRESS: begin
                if (!held_reg[s_key_code]) begin
                    if (fifo_stat.full) begin
                        drop_next = 1'b1;
                    end else begin
                        held_set        = 1'b1;
                        fifo_ctrl.push  = accept;
                        strobe_clr_next = 1'b0;
                    end
                end
            end
            ACT_RELEASE: held_clr = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strobe_clr_reg <= 1'b1;
            held_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                strobe_clr_reg <= strobe_clr_next;
                if (held_set) begin
                    held_reg[s_key_code] <= 1'b1;
                end else if (held_clr) begin
                    held_reg[s_key_code] <= 1'b0;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg   <= rd_next;
            drop_reg <= drop_next;
        end
    end

    kbl_key_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fifo_ctrl),
        .stat    (fifo_stat)
    );

    assign m_valid       = m_valid_reg;
    assign m_read_data   = rd_reg;
    assign m_key_dropped = drop_reg;

    a_drop_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_key_dropped) |-> (m_read_data == ZERO_BYTE))
        else $error("dropped key beat carries read data");

    a_push_marks_held: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_ctrl.push |=> (held_reg[$past(s_key_code)] && !strobe_clr_reg))
        else $error("queued key not marked held or strobe not set");

    a_pop_clears_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_ctrl.pop |=> strobe_clr_reg)
        else $error("pop left strobe set");

endmodule

@@ bench/testbench.sv @@
// self-checking bench for keyboard_latch_with_key_queue_top: directed and random key/bus traffic
// checked against an in-bench model of the key queue, held map and strobe flag
// depends on kbl_pkg and the block's rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kbl_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_ITEMS = 900;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [CODE_W-1:0] read_data;
        logic              key_dropped;
    } kbd_response_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [ADDR_W-1:0]   cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_action;
    logic [ADDR_W-1:0]   s_address;
    logic [CODE_W-1:0]   s_key_code;
    logic                m_valid;
    logic                m_ready;
    logic [CODE_W-1:0]   m_read_data;
    logic                m_key_dropped;

    keyboard_latch_with_key_queue_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_address     (s_address),
        .s_key_code    (s_key_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_key_dropped (m_key_dropped)
    );

    // latch model state
    logic [ADDR_W-1:0]   data_addr_q;
    logic [ADDR_W-1:0]   strobe_addr_q;
    logic [CODE_W-1:0]   key_store [QUEUE_DEPTH];
    int                  key_count;
    int                  key_head;
    bit [255:0]          key_held;
    bit                  strobe_cleared;

    kbd_response_t       response_q [$];

    int cycle_count;
    int items_sent;
    int useful_items;
    int results_seen;
    int error_count;
    int pop_count;
    int drop_count;
    int reg_writes;
    int ready_hold;
    bit no_idle;
    logic [CODE_W-1:0] pool_base;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 response_q.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(3, 1);
        else if (r < 97) return $urandom_range(10, 4);
        else return $urandom_range(60, 20);
    endfunction

    // mostly keys from a small pool so presses, repeats and releases collide
    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(99) < 75) return CODE_W'(pool_base + $urandom_range(23));
        return CODE_W'($urandom);
    endfunction

    function automatic kbd_response_t kbd_next_response(kbl_action_t act,
                                                        logic [ADDR_W-1:0] addr,
                                                        logic [CODE_W-1:0] code);
        kbd_response_t rsp;
        rsp.read_data   = ZERO_BYTE;
        rsp.key_dropped = 1'b0;
        case (act)
            ACT_READ: begin
                // data address wins when both registers hold the same address
                if (addr == data_addr_q) begin
                    if (key_count != 0) begin
                        strobe_cleared = 1'b0;
                        rsp.read_data  = key_store[key_head] | AVAIL_BIT;
                    end
                end else if (addr == strobe_addr_q) begin
                    rsp.read_data = strobe_cleared ? ZERO_BYTE : AVAIL_BIT;
                    if (!strobe_cleared && key_count != 0) begin
                        key_head       = (key_head + 1) % QUEUE_DEPTH;
                        key_count      = key_count - 1;
                        strobe_cleared = 1'b1;
                        pop_count++;
                    end
                end
            end
            ACT_PRESS: begin
                if (!key_held[code]) begin
                    if (key_count >= QUEUE_DEPTH) begin
                        rsp.key_dropped = 1'b1;
                        drop_count++;
                    end else begin
                        key_held[code] = 1'b1;
                        key_store[(key_head + key_count) % QUEUE_DEPTH] = code;
                        key_count      = key_count + 1;
                        strobe_cleared = 1'b0;
                    end
                end
            end
            ACT_RELEASE: key_held[code] = 1'b0;
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    // result side: random stalls, checked against the oldest expectation
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (!no_idle && $urandom_range(99) < 25) begin
            ready_hold <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        kbd_response_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (response_q.size() == 0) begin
                note_error($sformatf("unexpected result beat data=%02h dropped=%0b",
                                     m_read_data, m_key_dropped));
            end else begin
                want = response_q.pop_front();
                if (m_read_data !== want.read_data || m_key_dropped !== want.key_dropped)
                    note_error($sformatf("read_data exp %02h got %02h, key_dropped exp %0b got %0b",
                                         want.read_data, m_read_data,
                                         want.key_dropped, m_key_dropped));
            end
        end
    end

    task automatic send_event(input kbl_action_t act, input logic [ADDR_W-1:0] addr,
                              input logic [CODE_W-1:0] code);
        int gap;
        s_valid    <= 1'b1;
        s_action   <= act;
        s_address  <= addr;
        s_key_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        response_q.push_back(kbd_next_response(act, addr, code));
        items_sent++;
        if (act != ACT_WRITE) useful_items++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (response_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_DATA_ADDR) data_addr_q = val;
        else if (idx == REG_STROBE_ADDR) strobe_addr_q = val;
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_reads();
        send_event(ACT_READ, data_addr_q, 8'h00);
        send_event(ACT_READ, strobe_addr_q, 8'hFF);
        send_event(ACT_WRITE, data_addr_q, 8'hFF);
        send_event(ACT_READ, 16'h0000, 8'h00);
        send_event(ACT_READ, 16'hFFFF, 8'h00);
        send_event(ACT_WRITE, 16'hFFFF, 8'h00);
        send_event(ACT_RELEASE, 16'h0000, 8'h55);
    endtask

    task automatic test_press_and_pop();
        send_event(ACT_PRESS, 16'h0000, 8'h00);
        send_event(ACT_PRESS, 16'hFFFF, 8'h00);
        send_event(ACT_READ, data_addr_q, 8'h00);
        send_event(ACT_READ, strobe_addr_q, 8'h00);
        send_event(ACT_READ, strobe_addr_q, 8'h00);
        send_event(ACT_RELEASE, 16'h0000, 8'h00);
        send_event(ACT_PRESS, 16'h0000, 8'hFF);
        send_event(ACT_READ, data_addr_q, 8'h00);
        send_event(ACT_READ, strobe_addr_q, 8'h00);
        send_event(ACT_RELEASE, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_queue_overflow();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_event(ACT_PRESS, 16'h0000, CODE_W'(8'h40 + i));
        // full queue drops a new key but a held key is simply ignored
        send_event(ACT_PRESS, 16'h0000, 8'hAA);
        send_event(ACT_PRESS, 16'h0000, 8'h40);
        send_event(ACT_PRESS, 16'h0000, 8'hAA);
    endtask

    task automatic test_shared_address();
        write_reg(REG_DATA_ADDR, 16'h1234);
        write_reg(REG_STROBE_ADDR, 16'h1234);
        send_event(ACT_READ, 16'h1234, 8'h00);
        send_event(ACT_READ, 16'h1234, 8'h00);
    endtask

    task automatic test_ignored_index();
        write_reg(8'hFF, 16'hFFFF);
        write_reg(IDX_W'($urandom_range(254, 2)), ADDR_W'($urandom));
        send_event(ACT_READ, 16'h1234, 8'h00);
        send_event(ACT_READ, DATA_ADDR_RST, 8'h00);
    endtask

    task automatic run_traffic(input int stop_at);
        int kind;
        int n;
        while (useful_items < stop_at) begin
            no_idle = ($urandom_range(99) < 10);
            if ($urandom_range(99) < 3) wait_drained();
            kind = $urandom_range(99);
            if (kind < 45) begin
                // type a few keys, then read data and strobe for some of them
                n = $urandom_range(4, 1);
                repeat (n) send_event(ACT_PRESS, ADDR_W'($urandom), pick_code());
                repeat ($urandom_range(n, 0)) begin
                    send_event(ACT_READ, data_addr_q, CODE_W'($urandom));
                    send_event(ACT_READ, strobe_addr_q, CODE_W'($urandom));
                end
            end else if (kind < 57) begin
                repeat ($urandom_range(20, 10))
                    send_event(ACT_PRESS, ADDR_W'($urandom), pick_code());
            end else if (kind < 75) begin
                repeat ($urandom_range(10, 3))
                    send_event(ACT_RELEASE, ADDR_W'($urandom), pick_code());
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    n = $urandom_range(99);
                    send_event(kbl_action_t'($urandom_range(3)),
                               (n < 30) ? data_addr_q : (n < 60) ? strobe_addr_q
                                                                : ADDR_W'($urandom),
                               CODE_W'($urandom));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] set_data [4];
        logic [ADDR_W-1:0] set_strobe [4];
        int base;
        set_data[0] = 16'h0000;         set_strobe[0] = 16'hFFFF;
        set_data[1] = 16'hFFFF;         set_strobe[1] = 16'h0000;
        set_data[2] = ADDR_W'($urandom); set_strobe[2] = ADDR_W'($urandom);
        set_data[3] = DATA_ADDR_RST;    set_strobe[3] = STROBE_ADDR_RST;
        base = useful_items;
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_DATA_ADDR, set_data[p]);
            write_reg(REG_STROBE_ADDR, set_strobe[p]);
            write_reg(IDX_W'($urandom_range(255, 2)), ADDR_W'($urandom));
            pool_base = CODE_W'($urandom);
            run_traffic(base + (p + 1) * TARGET_ITEMS / 4);
        end
    endtask

    initial begin
        s_valid    <= 1'b0;
        s_action   <= ACT_READ;
        s_address  <= '0;
        s_key_code <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_DATA_ADDR;
        cfg_data   <= '0;
        m_ready    <= 1'b0;
        aresetn    <= 1'b0;
        cycle_count = 0;
        ready_hold  = 0;
        no_idle     = 1'b0;
        pool_base   = 8'h20;
        data_addr_q    = DATA_ADDR_RST;
        strobe_addr_q  = STROBE_ADDR_RST;
        key_count      = 0;
        key_head       = 0;
        key_held       = '0;
        strobe_cleared = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_reads();
        test_press_and_pop();
        test_queue_overflow();
        test_shared_address();
        test_ignored_index();
        test_random_traffic();

        wait_drained();
        repeat (5) @(posedge aclk);
        if (response_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived", response_q.size()));
        $display("covered %0d input beats (%0d ignored writes), %0d result beats, %0d mismatches",
                 items_sent, items_sent - useful_items, results_seen, error_count);
        $display("queue pops %0d, dropped presses %0d, register writes %0d",
                 pop_count, drop_count, reg_writes);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/kbl_pkg.sv
src/kbl_key_fifo.sv
src/keyboard_latch_with_key_queue_top.sv
bench/testbench.sv
